[rtl/core/fern_pkg.sv]
// ----------------------------------------------------------------------------
// fern_pkg
// Shared types, constants and map tables for the fern point generator.
// ----------------------------------------------------------------------------
package fern_pkg;

	// Canvas and field widths
	localparam int CANVAS_SIZE = 1000;
	localparam int PIXEL_W     = 10;
	localparam int ORIGIN_W    = 13;
	localparam int ZOOM_W      = 32;
	localparam int POINT_W     = 32;
	localparam int RAND_W      = 16;
	localparam int COLOR_W     = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int COEF_W      = 25;
	localparam int ADD_W       = 28;
	localparam int WIDE_W      = 71;
	localparam int MUL_W       = 33;
	localparam int PIX_CALC_W  = 33;
	localparam int FRAC_BITS   = 40;
	localparam int Q_FRAC      = 24;

	typedef logic signed [WIDE_W-1:0]     wide_t;
	typedef logic signed [MUL_W-1:0]      mul_op_t;
	typedef logic signed [2*MUL_W-1:0]    mul_res_t;
	typedef logic signed [PIX_CALC_W-1:0] pix_calc_t;
	typedef logic signed [POINT_W-1:0]    point_t;

	// Fixed-point constants
	localparam point_t Q_ONE      = 32'sh0100_0000;
	localparam point_t POINT_MAX  = 32'sh7FFF_FFFF;
	localparam point_t POINT_MIN  = 32'sh8000_0000;
	localparam wide_t  ROUND_HALF = wide_t'(1) <<< (Q_FRAC - 1);

	// Map selection thresholds
	localparam logic [RAND_W-1:0] SEL_TOP   = 16'd55705;
	localparam logic [RAND_W-1:0] SEL_LEFT  = 16'd60293;
	localparam logic [RAND_W-1:0] SEL_RIGHT = 16'd64880;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM     = 2'd2;

	localparam logic signed [ORIGIN_W-1:0] ORIGIN_X_RST = 13'sd500;
	localparam logic signed [ORIGIN_W-1:0] ORIGIN_Y_RST = 13'sd900;
	localparam logic [ZOOM_W-1:0]          ZOOM_RST     = 32'd65536;
	localparam logic signed [ORIGIN_W:0]   ORIGIN_X_OFS = 14'sd10;

	// Color classes
	localparam logic [COLOR_W-1:0] COLOR_GREEN  = 2'd0;
	localparam logic [COLOR_W-1:0] COLOR_FOREST = 2'd1;
	localparam logic [COLOR_W-1:0] COLOR_DARK   = 2'd2;

	typedef enum logic [1:0] {
		MAP_TOP,
		MAP_LEFT,
		MAP_RIGHT,
		MAP_STEM
	} map_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_ROUND,
		ST_PMUL,
		ST_P10,
		ST_P90,
		ST_PFIN
	} st_t;

	// Coefficients of one map, Q.24
	typedef struct packed {
		logic signed [COEF_W-1:0] xa;
		logic signed [COEF_W-1:0] xb;
		logic signed [COEF_W-1:0] ya;
		logic signed [COEF_W-1:0] yb;
		logic signed [ADD_W-1:0]  y_add;
	} coef_t;

	function automatic map_t map_of(logic [RAND_W-1:0] r);
		map_t m;
		if (r < SEL_TOP) begin
			m = MAP_TOP;
		end else if (r < SEL_LEFT) begin
			m = MAP_LEFT;
		end else if (r < SEL_RIGHT) begin
			m = MAP_RIGHT;
		end else begin
			m = MAP_STEM;
		end
		return m;
	endfunction

	function automatic logic [COLOR_W-1:0] color_of(map_t m);
		logic [COLOR_W-1:0] c;
		case (m)
			MAP_LEFT:  c = COLOR_FOREST;
			MAP_RIGHT: c = COLOR_DARK;
			default:   c = COLOR_GREEN;
		endcase
		return c;
	endfunction

	function automatic coef_t coef_of(map_t m);
		coef_t c;
		case (m)
			MAP_TOP: begin
				c.xa    =  25'sd14092861;
				c.xb    = -25'sd754975;
				c.ya    =  25'sd754975;
				c.yb    =  25'sd14428406;
				c.y_add =  28'sd26843546;
			end
			MAP_LEFT: begin
				c.xa    =  25'sd4194304;
				c.xb    = -25'sd4362076;
				c.ya    =  25'sd3858760;
				c.yb    =  25'sd4194304;
				c.y_add =  28'sd26843546;
			end
			MAP_RIGHT: begin
				c.xa    = -25'sd2264924;
				c.xb    =  25'sd4697620;
				c.ya    =  25'sd4362076;
				c.yb    =  25'sd4110418;
				c.y_add =  28'sd7381975;
			end
			default: begin
				// stem: x collapses to zero, y shrinks
				c.xa    =  25'sd0;
				c.xb    =  25'sd0;
				c.ya    =  25'sd0;
				c.yb    =  25'sd2684355;
				c.y_add =  28'sd0;
			end
		endcase
		return c;
	endfunction

endpackage

[rtl/core/fern_ifs_point_generator.sv]
// ----------------------------------------------------------------------------
// fern_ifs_point_generator
// Chaos-game fern generator: one random value in, one plotted pixel or none out.
// ----------------------------------------------------------------------------
// Each accepted transaction keeps in_ready low until the sequencer is back in
// idle, so no new transaction is taken while one is in work: the two affine
// products of each new coordinate, their rounding and saturation, and the zoom
// product of each pixel all go through one shared 33x33 multiplier under a step
// sequencer (three steps per coordinate, four per projection, plus the idle
// step in which the next transaction is taken). The pixel result waits in an
// output register, so the next transaction can start while it is still
// pending; the sequencer only holds in its last step if the previous result
// has not been taken. Configuration writes are taken at any time and must be
// done while idle.
module fern_ifs_point_generator (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic [fern_pkg::RAND_W-1:0]              random_value,
	input  logic                                     restart,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [fern_pkg::PIXEL_W-1:0]             pixel_x,
	output logic [fern_pkg::PIXEL_W-1:0]             pixel_y,
	output logic [fern_pkg::COLOR_W-1:0]             color_class,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [fern_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [fern_pkg::CFG_DATA_W-1:0]          cfg_data
);

	fern_pkg::st_t st_q, st_nxt;

	logic signed [fern_pkg::ORIGIN_W-1:0] origin_x_q, origin_y_q;
	logic [fern_pkg::ZOOM_W-1:0]          zoom_q;

	fern_pkg::point_t point_x_q, point_y_q, nx_q;
	fern_pkg::map_t   map_q;
	fern_pkg::wide_t  wide_q;
	logic             axis_q;
	logic [fern_pkg::PIXEL_W-1:0] px_q;
	logic             hit_x_q;

	logic                          out_valid_q;
	logic [fern_pkg::PIXEL_W-1:0]  pixel_x_q, pixel_y_q;
	logic [fern_pkg::COLOR_W-1:0]  color_q;

	fern_pkg::coef_t    coef;
	fern_pkg::mul_op_t  mul_a, mul_b;
	fern_pkg::mul_res_t mul_p;
	fern_pkg::point_t   p_sel;
	logic [fern_pkg::POINT_W-1:0] mag;
	logic               neg;
	logic               accept;
	logic               out_blocked;
	logic               fin_done;

	logic signed [fern_pkg::WIDE_W-fern_pkg::Q_FRAC-1:0] q_rnd;
	logic signed [fern_pkg::WIDE_W-fern_pkg::Q_FRAC:0]   sum_rnd;
	logic signed [fern_pkg::ADD_W-1:0]                   add_sel;
	fern_pkg::point_t   sat_rnd;
	logic               rnd_ovf;

	logic [fern_pkg::WIDE_W-fern_pkg::FRAC_BITS-2:0] ip;
	logic               frac;
	fern_pkg::pix_calc_t base_s, pix_s;
	logic               hit;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= fern_pkg::ORIGIN_X_RST;
			origin_y_q <= fern_pkg::ORIGIN_Y_RST;
			zoom_q     <= fern_pkg::ZOOM_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fern_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data[fern_pkg::ORIGIN_W-1:0];
				fern_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data[fern_pkg::ORIGIN_W-1:0];
				fern_pkg::REG_ZOOM:     zoom_q     <= cfg_data[fern_pkg::ZOOM_W-1:0];
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			fern_pkg::ST_IDLE:  if (in_valid) st_nxt = fern_pkg::ST_MUL_A;
			fern_pkg::ST_MUL_A: st_nxt = fern_pkg::ST_MUL_B;
			fern_pkg::ST_MUL_B: st_nxt = fern_pkg::ST_ROUND;
			fern_pkg::ST_ROUND: st_nxt = axis_q ? fern_pkg::ST_PMUL : fern_pkg::ST_MUL_A;
			fern_pkg::ST_PMUL:  st_nxt = fern_pkg::ST_P10;
			fern_pkg::ST_P10:   st_nxt = fern_pkg::ST_P90;
			fern_pkg::ST_P90:   st_nxt = fern_pkg::ST_PFIN;
			fern_pkg::ST_PFIN: begin
				if (!axis_q) begin
					st_nxt = fern_pkg::ST_PMUL;
				end else if (!out_blocked) begin
					st_nxt = fern_pkg::ST_IDLE;
				end
			end
			default: st_nxt = fern_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fern_pkg::ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	// Sequencer outputs: handshake and multiplier operand select
	assign coef        = fern_pkg::coef_of(map_q);
	assign p_sel       = axis_q ? point_y_q : point_x_q;
	assign mag         = p_sel[fern_pkg::POINT_W-1] ? -p_sel : p_sel;
	assign out_blocked = out_valid_q && !out_ready;

	always_comb begin
		in_ready = 1'b0;
		fin_done = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (st_q)
			fern_pkg::ST_IDLE: in_ready = 1'b1;
			fern_pkg::ST_MUL_A: begin
				mul_a = fern_pkg::mul_op_t'(point_x_q);
				mul_b = fern_pkg::mul_op_t'(axis_q ? coef.ya : coef.xa);
			end
			fern_pkg::ST_MUL_B: begin
				mul_a = fern_pkg::mul_op_t'(point_y_q);
				mul_b = fern_pkg::mul_op_t'(axis_q ? coef.yb : coef.xb);
			end
			fern_pkg::ST_PMUL: begin
				mul_a = {1'b0, mag};
				mul_b = {1'b0, zoom_q};
			end
			fern_pkg::ST_PFIN: fin_done = axis_q && !out_blocked;
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

	// Shared multiplier
	assign mul_p = mul_a * mul_b;

	// Round to Q.24, add the map constant, saturate
	assign add_sel = axis_q ? coef.y_add : '0;
	assign q_rnd   = wide_q[fern_pkg::WIDE_W-1:fern_pkg::Q_FRAC];
	assign sum_rnd = {q_rnd[$high(q_rnd)], q_rnd} + ($bits(sum_rnd))'(add_sel);
	assign rnd_ovf = !((&sum_rnd[$high(sum_rnd):fern_pkg::POINT_W-1]) ||
	                   !(|sum_rnd[$high(sum_rnd):fern_pkg::POINT_W-1]));

	always_comb begin
		if (rnd_ovf) begin
			sat_rnd = sum_rnd[$high(sum_rnd)] ? fern_pkg::POINT_MIN : fern_pkg::POINT_MAX;
		end else begin
			sat_rnd = sum_rnd[fern_pkg::POINT_W-1:0];
		end
	end

	// Pixel projection: floor(base +/- 90 * |p| * zoom / 2^40)
	assign ip     = wide_q[fern_pkg::WIDE_W-2:fern_pkg::FRAC_BITS];
	assign frac   = |wide_q[fern_pkg::FRAC_BITS-1:0];
	assign neg    = axis_q ? !point_y_q[fern_pkg::POINT_W-1] : point_x_q[fern_pkg::POINT_W-1];
	assign base_s = axis_q ? fern_pkg::pix_calc_t'(origin_y_q)
	                       : fern_pkg::pix_calc_t'(origin_x_q) -
	                         fern_pkg::pix_calc_t'(fern_pkg::ORIGIN_X_OFS);
	assign pix_s  = neg ? base_s - fern_pkg::pix_calc_t'(ip) - fern_pkg::pix_calc_t'(frac)
	                    : base_s + fern_pkg::pix_calc_t'(ip);
	assign hit    = (pix_s >= fern_pkg::pix_calc_t'(1)) &&
	                (pix_s <= fern_pkg::pix_calc_t'(fern_pkg::CANVAS_SIZE - 1));

	// Point state and step datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q <= fern_pkg::Q_ONE;
			point_y_q <= '0;
			axis_q    <= 1'b0;
		end else begin
			if (accept && restart) begin
				point_x_q <= fern_pkg::Q_ONE;
				point_y_q <= '0;
			end
			if (st_q == fern_pkg::ST_ROUND) begin
				axis_q <= !axis_q;
				if (axis_q) begin
					point_x_q <= nx_q;
					point_y_q <= sat_rnd;
				end
			end
			if (st_q == fern_pkg::ST_PFIN && (!axis_q || !out_blocked)) begin
				axis_q <= !axis_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			map_q <= fern_pkg::map_of(random_value);
		end
		case (st_q)
			fern_pkg::ST_MUL_A: wide_q <= fern_pkg::wide_t'(mul_p) + fern_pkg::ROUND_HALF;
			fern_pkg::ST_MUL_B: wide_q <= wide_q + fern_pkg::wide_t'(mul_p);
			fern_pkg::ST_ROUND: if (!axis_q) nx_q <= sat_rnd;
			fern_pkg::ST_PMUL:  wide_q <= fern_pkg::wide_t'(mul_p);
			fern_pkg::ST_P10:   wide_q <= (wide_q <<< 3) + (wide_q <<< 1);
			fern_pkg::ST_P90:   wide_q <= (wide_q <<< 3) + wide_q;
			fern_pkg::ST_PFIN: begin
				if (!axis_q) begin
					px_q    <= pix_s[fern_pkg::PIXEL_W-1:0];
					hit_x_q <= hit;
				end
			end
			default: ;
		endcase
	end

	// Output register: load a hit, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_done && hit && hit_x_q) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_done && hit && hit_x_q) begin
			pixel_x_q <= px_q;
			pixel_y_q <= pix_s[fern_pkg::PIXEL_W-1:0];
			color_q   <= fern_pkg::color_of(map_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign color_class = color_q;

endmodule

[rtl/core/fern_checker.sv]
// ----------------------------------------------------------------------------
// fern_checker
// Port-level checks for the fern point generator, bound to the top level.
// ----------------------------------------------------------------------------
module fern_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [fern_pkg::PIXEL_W-1:0]        pixel_x,
	input logic [fern_pkg::PIXEL_W-1:0]        pixel_y,
	input logic [fern_pkg::COLOR_W-1:0]        color_class
);

	// Busy after taking a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after a transaction");

	// Pending result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x) &&
		$stable(pixel_y) && $stable(color_class))
		else $error("pending result changed");

	// A new result comes only out of a busy step
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

	// Only three color classes exist
	a_color_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> color_class <= fern_pkg::COLOR_DARK)
		else $error("invalid color class");

endmodule

bind fern_ifs_point_generator fern_checker u_fern_checker (.*);
